// ----- hw/rtl/srs_pkg.sv -----
`default_nettype none

package srs_pkg;

  localparam int unsigned SCORE_W = 8;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned RANK_W  = 7;

  typedef struct packed {
    logic load;
    logic start;
    logic emit;
    logic clear;
  } srs_cmd_t;

  typedef struct packed {
    logic busy;
    logic found;
    logic last;
  } srs_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/srs_ram.sv -----
`default_nettype none

module srs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/srs_datapath.sv -----
`default_nettype none

module srs_datapath #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srs_pkg::srs_cmd_t             cmd_i,
  output srs_pkg::srs_sts_t                  sts_o,
  input  wire logic [srs_pkg::SCORE_W-1:0]   score_i,
  output logic      [srs_pkg::IDX_W-1:0]     entry_index_o,
  output logic      [srs_pkg::SCORE_W-1:0]   entry_score_o,
  output logic      [srs_pkg::RANK_W-1:0]    rank_o,
  output logic                               final_res_o
);
  import srs_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       nz_q, nz_d;
  logic [RANK_W-1:0]      rank_q, rank_d;
  logic [MAX_ENTRIES-1:0] done_q, done_d;
  logic                   active_q, active_d;
  logic [CNT_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]      rd_idx_q;
  logic [SCORE_W-1:0]     best_score_q, best_score_d;
  logic [ADDR_W-1:0]      best_idx_q, best_idx_d;
  logic [IDX_W-1:0]       out_idx_q;
  logic [SCORE_W-1:0]     out_score_q;
  logic [RANK_W-1:0]      out_rank_q;
  logic                   out_final_q;

  logic                   we;
  logic                   issue;
  logic [SCORE_W-1:0]     rd_data;
  logic [RANK_W-1:0]      next_rank;

  assign we        = cmd_i.load && (cnt_q < CNT_W'(MAX_ENTRIES));
  assign issue     = active_q && (rd_ptr_q < cnt_q);
  assign next_rank = rank_q + RANK_W'(1);

  srs_ram #(
    .WIDTH(SCORE_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(score_i),
    .raddr_i(rd_ptr_q[ADDR_W-1:0]),
    .rdata_o(rd_data)
  );

  always_comb begin
    cnt_d        = cnt_q;
    nz_d         = nz_q;
    rank_d       = rank_q;
    done_d       = done_q;
    active_d     = active_q;
    rd_ptr_d     = rd_ptr_q;
    rd_vld_d     = issue;
    best_score_d = best_score_q;
    best_idx_d   = best_idx_q;

    if (we) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (score_i != '0) begin
        nz_d = nz_q + CNT_W'(1);
      end
    end

    if (active_q) begin
      if (issue) begin
        rd_ptr_d = rd_ptr_q + CNT_W'(1);
      end else begin
        active_d = 1'b0;
      end
    end

    if (rd_vld_q && !done_q[rd_idx_q] && (rd_data > best_score_q)) begin
      best_score_d = rd_data;
      best_idx_d   = rd_idx_q;
    end

    if (cmd_i.start) begin
      active_d     = 1'b1;
      rd_ptr_d     = '0;
      best_score_d = '0;
      best_idx_d   = '0;
    end

    if (cmd_i.emit) begin
      done_d[best_idx_q] = 1'b1;
      rank_d             = next_rank;
    end

    if (cmd_i.clear) begin
      cnt_d  = '0;
      nz_d   = '0;
      rank_d = '0;
      done_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      nz_q     <= '0;
      rank_q   <= '0;
      done_q   <= '0;
      active_q <= 1'b0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      nz_q     <= nz_d;
      rank_q   <= rank_d;
      done_q   <= done_d;
      active_q <= active_d;
      rd_ptr_q <= rd_ptr_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_ptr_q[ADDR_W-1:0];
    best_score_q <= best_score_d;
    best_idx_q   <= best_idx_d;
    if (cmd_i.emit) begin
      out_idx_q   <= IDX_W'(best_idx_q);
      out_score_q <= best_score_q;
      out_rank_q  <= next_rank;
      out_final_q <= (next_rank == RANK_W'(nz_q));
    end
  end

  assign sts_o.busy  = active_q || rd_vld_q;
  assign sts_o.found = (best_score_q != '0);
  assign sts_o.last  = out_final_q;

  assign entry_index_o = out_idx_q;
  assign entry_score_o = out_score_q;
  assign rank_o        = out_rank_q;
  assign final_res_o   = out_final_q;

  a_emit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (best_score_q != '0) && !done_q[best_idx_q])
    else $error("emit of a zero or already ranked entry");

  a_rank_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    RANK_W'(nz_q) >= rank_q)
    else $error("rank count beyond non-zero entries");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(MAX_ENTRIES)) && (nz_q <= cnt_q))
    else $error("entry counts out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/srs_ctrl.sv -----
`default_nettype none

module srs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              last_entry_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output srs_pkg::srs_cmd_t      cmd_o,
  input  wire srs_pkg::srs_sts_t sts_i
);
  import srs_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          if (last_entry_i) begin
            state_d    = ST_START;
            in_ready_d = 1'b0;
          end
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts_i.busy) begin
          if (sts_i.found) begin
            cmd_o.emit  = 1'b1;
            state_d     = ST_EMIT;
            out_valid_d = 1'b1;
          end else begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
            in_ready_d  = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (sts_i.last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
            in_ready_d  = 1'b1;
          end else begin
            state_d = ST_START;
          end
        end
      end
      default: begin
        state_d     = ST_LOAD;
        in_ready_d  = 1'b1;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  a_ready_in_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q == (state_q == ST_LOAD))
    else $error("input ready outside load phase");

  a_valid_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q == (state_q == ST_EMIT))
    else $error("output valid outside emit phase");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.start, cmd_o.emit, cmd_o.clear}))
    else $error("more than one datapath command");

endmodule

`default_nettype wire

// ----- hw/rtl/score_rank_sorter_top.sv -----
// Score rank sorter.
// Input channel (in_valid_i/in_ready_o): one score per item, loaded in index
// order into a store of MAX_ENTRIES entries; loads past a full store are
// dropped. An item with last_entry_i set is loaded and then starts ranking.
// Input ready is high only while the block loads a set.
// Output channel (out_valid_o/out_ready_i): one item per non-zero score, in
// descending score order, equal scores by ascending index, with a 1-based
// rank; final_res_o marks the last one. An all-zero or empty set gives none.
// Each result takes one scan over the n loaded entries of the store memory;
// valid rises after that scan, so a set with k non-zero scores takes k scans
// plus receiver stall time. The block loads one item per cycle while input
// ready is high.
// A stalled receiver holds the result register and the scan waits.
// After the final result, or after a scan that finds nothing, the set is
// emptied and the next input item starts a new set.
// Reset empties the set and returns to loading; store contents need none.
`default_nettype none

module score_rank_sorter_top #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [srs_pkg::SCORE_W-1:0]   score_i,
  input  wire logic                          last_entry_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [srs_pkg::IDX_W-1:0]     entry_index_o,
  output logic      [srs_pkg::SCORE_W-1:0]   entry_score_o,
  output logic      [srs_pkg::RANK_W-1:0]    rank_o,
  output logic                               final_res_o
);
  import srs_pkg::*;

  srs_cmd_t cmd;
  srs_sts_t sts;

  srs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_entry_i(last_entry_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  srs_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .score_i      (score_i),
    .entry_index_o(entry_index_o),
    .entry_score_o(entry_score_o),
    .rank_o       (rank_o),
    .final_res_o  (final_res_o)
  );

endmodule

`default_nettype wire
